// File: design/sktab_pkg.sv
package sktab_pkg;

  localparam int unsigned KEY_W    = 15;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REC_W    = KEY_W + 3 * BYTE_W;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned TOTAL_W  = 7;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_OVERWRITTEN = 3'd1,
    ST_DELETED     = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     position;
    logic [TOTAL_W-1:0]   entry_total;
  } result_t;

endpackage

// File: design/sktab_mem.sv
module sktab_mem #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]           rd_addr_i,
  output logic [sktab_pkg::REC_W-1:0]        rd_data_o,
  input  logic                               wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]           wr_addr_i,
  input  logic [sktab_pkg::REC_W-1:0]        wr_data_i
);

  logic [sktab_pkg::REC_W-1:0] mem_q [DEPTH];
  logic [sktab_pkg::REC_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/sktab_seq.sv
module sktab_seq #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  req_valid_i,
  output logic                                  req_ready_o,
  input  sktab_pkg::req_e                       req_type_i,
  input  logic [sktab_pkg::REC_W-1:0]           req_rec_i,
  output logic                                  mem_rd_en_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]        mem_rd_addr_o,
  input  logic [sktab_pkg::REC_W-1:0]           mem_rd_data_i,
  output logic                                  mem_wr_en_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]        mem_wr_addr_o,
  output logic [sktab_pkg::REC_W-1:0]           mem_wr_data_o,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output sktab_pkg::result_t                    res_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE     = CW'(1);

  sktab_pkg::state_e  state_q, state_d;
  sktab_pkg::req_e    req_q;
  sktab_pkg::status_e status_q, status_d;

  logic [sktab_pkg::REC_W-1:0] rec_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] chk_q, chk_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] slot_q, slot_d;
  logic [CW-1:0] src_q, src_d;
  logic [CW-1:0] dst_q, dst_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          spend_q, spend_d;

  logic [sktab_pkg::KEY_W-1:0] key_q, rd_key;
  logic          hit, scan_end, match;
  logic [CW-1:0] fslot;
  logic          up;
  logic [CW+sktab_pkg::POS_W-1:0]   pos_ext;
  logic [CW+sktab_pkg::TOTAL_W-1:0] tot_ext;

  assign key_q  = rec_q[sktab_pkg::REC_W-1 -: sktab_pkg::KEY_W];
  assign rd_key = mem_rd_data_i[sktab_pkg::REC_W-1 -: sktab_pkg::KEY_W];

  // first slot whose key is not below the request key
  assign hit      = pend_q && (rd_key >= key_q);
  assign scan_end = !hit && (scan_q == count_q);
  assign match    = hit && (rd_key == key_q);
  assign fslot    = hit ? chk_q : count_q;
  assign up       = (req_q == sktab_pkg::REQ_INSERT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sktab_pkg::S_IDLE: begin
        if (req_valid_i) state_d = sktab_pkg::S_SEARCH;
      end
      sktab_pkg::S_SEARCH: begin
        if (hit || scan_end) begin
          if (up && !match && count_q != MAX_CNT) state_d = sktab_pkg::S_SHIFT;
          else if (!up && match)                  state_d = sktab_pkg::S_SHIFT;
          else                                    state_d = sktab_pkg::S_DONE;
        end
      end
      sktab_pkg::S_SHIFT: begin
        if (rem_q == '0 && !spend_q) state_d = sktab_pkg::S_DONE;
      end
      sktab_pkg::S_DONE: begin
        if (res_ready_i) state_d = sktab_pkg::S_IDLE;
      end
      default: state_d = sktab_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = scan_q[AW-1:0];
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = slot_q[AW-1:0];
    mem_wr_data_o = rec_q;
    scan_d   = scan_q;
    chk_d    = chk_q;
    pend_d   = pend_q;
    slot_d   = slot_q;
    src_d    = src_q;
    dst_d    = dst_q;
    rem_d    = rem_q;
    spend_d  = spend_q;
    count_d  = count_q;
    status_d = status_q;
    case (state_q)
      sktab_pkg::S_IDLE: begin
        scan_d = '0;
        pend_d = 1'b0;
      end
      sktab_pkg::S_SEARCH: begin
        if (hit || scan_end) begin
          spend_d = 1'b0;
          if (up) begin
            if (match) begin
              // overwrite in place
              mem_wr_en_o   = 1'b1;
              mem_wr_addr_o = fslot[AW-1:0];
              status_d      = sktab_pkg::ST_OVERWRITTEN;
              slot_d        = fslot;
            end else if (count_q == MAX_CNT) begin
              status_d = sktab_pkg::ST_FULL;
              slot_d   = '0;
            end else begin
              status_d = sktab_pkg::ST_INSERTED;
              slot_d   = fslot;
              rem_d    = count_q - fslot;
              src_d    = count_q - ONE;
              count_d  = count_q + ONE;
            end
          end else begin
            if (match) begin
              status_d = sktab_pkg::ST_DELETED;
              slot_d   = fslot;
              rem_d    = count_q - ONE - fslot;
              src_d    = fslot + ONE;
              count_d  = count_q - ONE;
            end else begin
              status_d = sktab_pkg::ST_NOT_FOUND;
              slot_d   = '0;
            end
          end
        end else begin
          // one read per cycle, compared on the next
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = scan_q[AW-1:0];
          chk_d         = scan_q;
          pend_d        = 1'b1;
          scan_d        = scan_q + ONE;
        end
      end
      sktab_pkg::S_SHIFT: begin
        // read one entry, write it one slot over in the next cycle
        if (rem_q != '0) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = src_q[AW-1:0];
          src_d         = up ? src_q - ONE : src_q + ONE;
          dst_d         = up ? src_q + ONE : src_q - ONE;
          rem_d         = rem_q - ONE;
          spend_d       = 1'b1;
        end else begin
          spend_d = 1'b0;
        end
        if (spend_q) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = dst_q[AW-1:0];
          mem_wr_data_o = mem_rd_data_i;
        end else if (rem_q == '0 && up) begin
          // gap is open, place the new record
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = slot_q[AW-1:0];
          mem_wr_data_o = rec_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sktab_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      spend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      spend_q <= spend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sktab_pkg::S_IDLE && req_valid_i) begin
      req_q <= req_type_i;
      rec_q <= req_rec_i;
    end
    scan_q   <= scan_d;
    chk_q    <= chk_d;
    slot_q   <= slot_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    rem_q    <= rem_d;
    status_q <= status_d;
  end

  assign req_ready_o = (state_q == sktab_pkg::S_IDLE);
  assign res_valid_o = (state_q == sktab_pkg::S_DONE);

  assign pos_ext = {{sktab_pkg::POS_W{1'b0}}, slot_q};
  assign tot_ext = {{sktab_pkg::TOTAL_W{1'b0}}, count_q};

  always_comb begin
    res_o.status      = status_q;
    res_o.position    = pos_ext[sktab_pkg::POS_W-1:0];
    res_o.entry_total = tot_ext[sktab_pkg::TOTAL_W-1:0];
  end

  // same-cycle read and write never touch one entry, so no bypass is needed
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd_en_o && mem_wr_en_o |-> mem_rd_addr_o != mem_wr_addr_o)
    else $error("read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("entry count beyond table size");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_q == sktab_pkg::ST_FULL |-> count_q == MAX_CNT)
    else $error("full reported on a table with free slots");

  a_accept_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == sktab_pkg::S_SEARCH)
    else $error("accepted word did not start a search");

  a_count_stable_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sktab_pkg::S_SEARCH && $past(state_q == sktab_pkg::S_SEARCH)
    |-> $stable(count_q))
    else $error("entry count moved during search");

endmodule

// File: design/sktab_out.sv
module sktab_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_ready_o,
  input  sktab_pkg::result_t  res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sktab_pkg::result_t  out_o
);

  logic               valid_q, valid_d;
  sktab_pkg::result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) valid_d = res_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) data_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// File: design/sorted_key_table_core.sv
// sorted key table: records kept in ascending key order in one on-chip ram
// slave channel carries one request word: tuser holds the request type
// (insert or overwrite, delete), tdata holds key, age, sex code and section
// master channel returns one result word per request: tuser holds the status,
// tdata holds the zero-based position and the entry total after the request
// a request is taken only while the sequencer is idle; one at a time
// a request runs in steps, with n = entries before and s = affected slot:
//   search: one ram read per cycle, compare on the next, from slot 0 until
//   an entry at or above the key is found or the scan runs past the last one
//   shift of m entries: m reads one per cycle, each entry written one slot
//   over, then a closing step places an inserted record;
//   m = n - s for a new key, n - s - 1 for a delete
//   overwrite, not found and full skip the shift and go to the result
// throughput is set by the single read port scanning and shifting entries
// results go to an output register; the next request is taken while a result
// waits there, and the sequencer holds only if a second result is ready
// before the first is taken
// reset clears the entry count and all handshake state; the ram needs no
// clearing since only slots below the entry count are ever read
module sorted_key_table_core #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_id[14:0], age[22:15], sex_code[30:23], section[38:31], zero pad
  input  logic [39:0] s_axis_tdata,
  // req_type[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position[5:0], entry_total[12:6], zero pad
  output logic [15:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);

  logic [sktab_pkg::REC_W-1:0] req_rec;
  sktab_pkg::req_e             req_type;

  logic                        mem_rd_en, mem_wr_en;
  logic [AW-1:0]               mem_rd_addr, mem_wr_addr;
  logic [sktab_pkg::REC_W-1:0] mem_rd_data, mem_wr_data;

  logic               res_valid, res_ready;
  sktab_pkg::result_t res, out_res;

  // record layout in ram: key, age, sex code, section from the top bit down
  assign req_rec  = {s_axis_tdata[14:0], s_axis_tdata[22:15],
                     s_axis_tdata[30:23], s_axis_tdata[38:31]};
  assign req_type = sktab_pkg::req_e'(s_axis_tuser[0]);

  sktab_mem #(
    .DEPTH (MAX_ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // search, shift and place sequencer around the ram
  sktab_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_type_i    (req_type),
    .req_rec_i     (req_rec),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // result word register toward the master channel
  sktab_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.entry_total, out_res.position};
  assign m_axis_tuser = out_res.status;

endmodule

// File: tb/sorted_key_table_core_tb.sv
`timescale 1ns / 100ps

module sorted_key_table_core_tb;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned POOL_SIZE    = 96;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned SEGMENT_LEN  = 160;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [sktab_pkg::KEY_W-1:0]  key;
    logic [sktab_pkg::BYTE_W-1:0] age;
    logic [sktab_pkg::BYTE_W-1:0] sex;
    logic [sktab_pkg::BYTE_W-1:0] sect;
  } record_t;

  typedef struct packed {
    sktab_pkg::req_e req;
    record_t         rec;
  } edit_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // requests not yet driven, and the generator's view of which keys are live
  edit_req_t                   pending_reqs[$];
  logic [sktab_pkg::KEY_W-1:0] live_keys[$];
  logic [sktab_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  // predicted table contents and the results still owed by the block
  record_t            sorted_recs[TABLE_DEPTH];
  int unsigned        rec_count = 0;
  sktab_pkg::result_t owed_results[$];

  int unsigned total_reqs = 0;
  int unsigned taken_reqs = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 58;

  sorted_key_table_core #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int find_live(logic [sktab_pkg::KEY_W-1:0] key);
    foreach (live_keys[i]) begin
      if (live_keys[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic push_req(sktab_pkg::req_e req, logic [sktab_pkg::KEY_W-1:0] key,
                          logic [sktab_pkg::BYTE_W-1:0] age,
                          logic [sktab_pkg::BYTE_W-1:0] sex,
                          logic [sktab_pkg::BYTE_W-1:0] sect);
    edit_req_t w;
    int        idx;
    w.req      = req;
    w.rec.key  = key;
    w.rec.age  = age;
    w.rec.sex  = sex;
    w.rec.sect = sect;
    pending_reqs.push_back(w);
    idx = find_live(key);
    if (req == sktab_pkg::REQ_INSERT) begin
      if (idx < 0 && live_keys.size() < TABLE_DEPTH) live_keys.push_back(key);
    end else if (idx >= 0) begin
      live_keys.delete(idx);
    end
    total_reqs++;
  endtask

  // sorted insert / overwrite / delete, one result per request
  function automatic sktab_pkg::result_t apply_edit(sktab_pkg::req_e req, record_t rec);
    sktab_pkg::result_t res;
    int unsigned        slot;
    int unsigned        n;
    bit                 hit;
    n    = rec_count;
    slot = 0;
    while (slot < n && sorted_recs[slot].key < rec.key) slot++;
    hit = (slot < n) && (sorted_recs[slot].key == rec.key);
    res.position = '0;
    if (req == sktab_pkg::REQ_INSERT) begin
      if (hit) begin
        sorted_recs[slot] = rec;
        res.status   = sktab_pkg::ST_OVERWRITTEN;
        res.position = slot[sktab_pkg::POS_W-1:0];
      end else if (n >= TABLE_DEPTH) begin
        res.status = sktab_pkg::ST_FULL;
      end else begin
        for (int k = n; k > slot; k--) sorted_recs[k] = sorted_recs[k-1];
        sorted_recs[slot] = rec;
        rec_count    = n + 1;
        res.status   = sktab_pkg::ST_INSERTED;
        res.position = slot[sktab_pkg::POS_W-1:0];
      end
    end else if (hit) begin
      for (int k = slot; k + 1 < n; k++) sorted_recs[k] = sorted_recs[k+1];
      rec_count    = n - 1;
      res.status   = sktab_pkg::ST_DELETED;
      res.position = slot[sktab_pkg::POS_W-1:0];
    end else begin
      res.status = sktab_pkg::ST_NOT_FOUND;
    end
    res.entry_total = rec_count[sktab_pkg::TOTAL_W-1:0];
    return res;
  endfunction

  task automatic build_requests();
    bit                          is_insert;
    bit                          filling;
    int unsigned                 pick;
    logic [sktab_pkg::KEY_W-1:0] key;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 15'($urandom_range(32767));

    // directed: empty table, extremes of key and fields, every outcome but full
    push_req(sktab_pkg::REQ_DELETE, 15'd100,   8'h00, 8'h00, 8'h00);
    push_req(sktab_pkg::REQ_INSERT, 15'h4000,  8'hff, 8'h00, 8'hff);
    push_req(sktab_pkg::REQ_INSERT, 15'h0000,  8'h00, 8'hff, 8'h00);
    push_req(sktab_pkg::REQ_INSERT, 15'h7fff,  8'h80, 8'h01, 8'h7f);
    push_req(sktab_pkg::REQ_INSERT, 15'h2000,  8'h01, 8'h80, 8'hfe);
    push_req(sktab_pkg::REQ_INSERT, 15'h0000,  8'hff, 8'hff, 8'hff);
    push_req(sktab_pkg::REQ_INSERT, 15'h7fff,  8'h00, 8'h00, 8'h00);
    push_req(sktab_pkg::REQ_DELETE, 15'd12345, 8'hff, 8'hff, 8'hff);
    push_req(sktab_pkg::REQ_DELETE, 15'h2000,  8'h00, 8'h00, 8'h00);
    push_req(sktab_pkg::REQ_DELETE, 15'h0000,  8'h00, 8'h00, 8'h00);
    push_req(sktab_pkg::REQ_DELETE, 15'h7fff,  8'h00, 8'h00, 8'h00);
    push_req(sktab_pkg::REQ_DELETE, 15'h4000,  8'h00, 8'h00, 8'h00);
    push_req(sktab_pkg::REQ_INSERT, 15'h5555,  8'h55, 8'haa, 8'h55);
    push_req(sktab_pkg::REQ_INSERT, 15'h2aaa,  8'haa, 8'h55, 8'haa);
    push_req(sktab_pkg::REQ_DELETE, 15'h2aaa,  8'h00, 8'h00, 8'h00);
    push_req(sktab_pkg::REQ_DELETE, 15'h5555,  8'h00, 8'h00, 8'h00);

    // random: alternate fill-heavy and drain-heavy stretches so the table
    // runs up to full and back down to empty
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      filling   = ((i / SEGMENT_LEN) % 2) == 0;
      is_insert = filling ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
      pick      = $urandom_range(99);
      if (pick < 5) begin
        key = 15'($urandom_range(32767));
      end else if ((is_insert ? pick < 30 : pick < 90) && live_keys.size() > 0) begin
        key = live_keys[$urandom_range(live_keys.size() - 1)];
      end else begin
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
      end
      push_req(is_insert ? sktab_pkg::REQ_INSERT : sktab_pkg::REQ_DELETE, key,
               8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    end
  endtask

  // driver: next word goes out once the current one is taken
  always @(posedge clk_i) begin
    edit_req_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_reqs.pop_front();
        s_axis_tdata  <= {1'b0, w.rec.sect, w.rec.sex, w.rec.age, w.rec.key};
        s_axis_tuser  <= w.req;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure and idle phases
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (taken_reqs >= 2 * total_reqs / 3) begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end else if (taken_reqs >= total_reqs / 3) begin
      send_idle_pct <= 58;
      recv_idle_pct <= 29;
    end
  end

  // predict on every accepted request word
  always @(posedge clk_i) begin
    record_t rec;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      rec.key  = s_axis_tdata[14:0];
      rec.age  = s_axis_tdata[22:15];
      rec.sex  = s_axis_tdata[30:23];
      rec.sect = s_axis_tdata[38:31];
      owed_results.push_back(apply_edit(sktab_pkg::req_e'(s_axis_tuser[0]), rec));
      taken_reqs <= taken_reqs + 1;
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    sktab_pkg::result_t want;
    sktab_pkg::result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status      = sktab_pkg::status_e'(m_axis_tuser);
      got.position    = m_axis_tdata[5:0];
      got.entry_total = m_axis_tdata[12:6];
      if (owed_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected result: status %0d position %0d total %0d",
                   got.status, got.position, got.entry_total);
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status || got.position !== want.position ||
            got.entry_total !== want.entry_total) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch: status %0d/%0d position %0d/%0d total %0d/%0d (exp/act)",
                     want.status, got.status, want.position, got.position,
                     want.entry_total, got.entry_total);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** sorted_key_table_core: FAILED **");
      $finish;
    end
  end

  initial begin
    build_requests();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (taken_reqs < total_reqs || owed_results.size() != 0) @(posedge clk_i);
    // catch any stray result words after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** sorted_key_table_core: PASSED **");
    end else begin
      $display("** sorted_key_table_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/sktab_pkg.sv
design/sktab_mem.sv
design/sktab_seq.sv
design/sktab_out.sv
design/sorted_key_table_core.sv
tb/sorted_key_table_core_tb.sv
